[rtl/fir_horizontal_row_filter_top_macros.svh]
// Assertion macros for the horizontal row filter.
// Included by the RTL files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef FIR_HORIZONTAL_ROW_FILTER_TOP_MACROS_SVH
`define FIR_HORIZONTAL_ROW_FILTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define FHRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fhrf check failed");

// Next-cycle implication, sampled on clk, off while in reset
`define FHRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fhrf check failed");

`endif

[rtl/fhrf_pkg.sv]
// Shared types and constants of the horizontal row filter.
// No dependencies; used by the interfaces, the channel datapath and the top level.
package fhrf_pkg;

    // Coefficient registers and arithmetic format
    localparam int NUM_COEFS    = 7;
    localparam int COEF_W       = 16;
    localparam int FRAC_BITS    = 14;
    localparam int ROUND_BIAS   = 8192;
    localparam int OUT_W        = 16;
    localparam int OUT_MAX      = 32767;
    localparam int OUT_MIN      = -32768;

    // Configuration port
    localparam int CFG_IDX_W    = 3;
    localparam int TAP_CNT_W    = 3;
    localparam int HALF_W       = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE = 3'd1;

    localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RESET = 3'd1;
    localparam logic signed [COEF_W-1:0] COEF_UNITY  = 16'sd16384;

    // Colour channels
    localparam int NUM_CHANNELS = 3;
    localparam int CH_RED       = 0;
    localparam int CH_GREEN     = 1;
    localparam int CH_BLUE      = 2;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [OUT_W-1:0]  sample_t;

    // Load strobes for the two datapath stages
    typedef struct packed {
        logic prod_load;
        logic sum_load;
    } pipe_ctrl_t;

endpackage

[rtl/fhrf_if.sv]
// Handshake interfaces of the horizontal row filter: pixel input, result output, config writes.
// Depends on fhrf_pkg.
interface fhrf_pixel_if #(parameter int PIXEL_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] red_in;
    logic [PIXEL_BITS-1:0] green_in;
    logic [PIXEL_BITS-1:0] blue_in;
    logic                  row_last;

    modport source (output valid, red_in, green_in, blue_in, row_last, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, row_last, output ready);
endinterface

interface fhrf_result_if;
    logic              valid;
    logic              ready;
    fhrf_pkg::sample_t red_out;
    fhrf_pkg::sample_t green_out;
    fhrf_pkg::sample_t blue_out;
    logic              clipped;
    logic              row_end;
    logic              last_of_run;

    modport source (output valid, red_out, green_out, blue_out, clipped, row_end, last_of_run,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, clipped, row_end, last_of_run,
                    output ready);
endinterface

interface fhrf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fhrf_pkg::CFG_IDX_W-1:0]    index;
    logic [fhrf_pkg::COEF_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/fhrf_channel.sv]
// One colour channel of the filter datapath: tap products, then sum, round and saturate.
// Depends on fhrf_pkg; operands arrive already selected and zeroed by the top level.
module fhrf_channel #(
    parameter int PIXEL_BITS = 12
) (
    input  logic                  clk,
    input  fhrf_pkg::pipe_ctrl_t  ctrl,
    input  logic [PIXEL_BITS-1:0] operand [fhrf_pkg::NUM_COEFS],
    input  fhrf_pkg::coef_t       coef    [fhrf_pkg::NUM_COEFS],
    output fhrf_pkg::sample_t     value,
    output logic                  clip
);

    localparam int PROD_W = PIXEL_BITS + fhrf_pkg::COEF_W;
    localparam int SUM_W  = PROD_W + 3;
    localparam logic signed [SUM_W-1:0] SUM_BIAS = SUM_W'(fhrf_pkg::ROUND_BIAS);
    localparam logic signed [SUM_W-1:0] SAT_HI   = SUM_W'(fhrf_pkg::OUT_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO   = SUM_W'(fhrf_pkg::OUT_MIN);

    logic signed [PROD_W-1:0] prod_next [fhrf_pkg::NUM_COEFS];
    logic signed [PROD_W-1:0] prod_reg  [fhrf_pkg::NUM_COEFS];
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  rounded;
    fhrf_pkg::sample_t        value_next;
    fhrf_pkg::sample_t        value_reg;
    logic                     clip_next;
    logic                     clip_reg;

    // Multiply each tap: unsigned pixel times signed weight
    always_comb
    begin
        for (int t = 0; t < fhrf_pkg::NUM_COEFS; t++)
        begin
            prod_next[t] = PROD_W'($signed({1'b0, operand[t]})) * PROD_W'(coef[t]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.prod_load)
        begin
            prod_reg <= prod_next;
        end
    end

    // Add the products, round half up to input units, clamp to 16 bits
    always_comb
    begin
        sum = '0;
        for (int t = 0; t < fhrf_pkg::NUM_COEFS; t++)
        begin
            sum = sum + SUM_W'(prod_reg[t]);
        end
        rounded = (sum + SUM_BIAS) >>> fhrf_pkg::FRAC_BITS;
        clip_next = 1'b0;
        if (rounded > SAT_HI)
        begin
            value_next = fhrf_pkg::sample_t'(fhrf_pkg::OUT_MAX);
            clip_next  = 1'b1;
        end
        else if (rounded < SAT_LO)
        begin
            value_next = fhrf_pkg::sample_t'(fhrf_pkg::OUT_MIN);
            clip_next  = 1'b1;
        end
        else
        begin
            value_next = rounded[fhrf_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_load)
        begin
            value_reg <= value_next;
            clip_reg  <= clip_next;
        end
    end

    assign value = value_reg;
    assign clip  = clip_reg;

endmodule

[rtl/fir_horizontal_row_filter_top.sv]
// Horizontal row FIR filter: one pixel per clock in unless the input is held. A result passes from
// the job register through the product and output registers. A pixel that is not the last of its
// row gives at most one result and the next pixel can be taken in the following cycle unless the
// output stalls. The last pixel of a row gives one result for every pending column (up to half
// the tap count plus one, at most four) and the input is held while the job register issues the
// results beyond the first. The output register lets the next pixel in while a finished result
// waits. Config writes are always ready and must only be made while no pixel is in flight.
// Depends on fhrf_pkg, fhrf_if, fhrf_channel and the assertion macro header.
`include "fir_horizontal_row_filter_top_macros.svh"

module fir_horizontal_row_filter_top #(
    parameter int MAX_TAPS   = 7,
    parameter int PIXEL_BITS = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    fhrf_pixel_if.sink    pixel,
    fhrf_result_if.source result,
    fhrf_cfg_if.sink      cfg
);

    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TAPS);

    // Configuration registers
    logic [fhrf_pkg::TAP_CNT_W-1:0] tap_count_reg;
    fhrf_pkg::coef_t                coef_reg [fhrf_pkg::NUM_COEFS];

    // Row history, newest first
    logic [PIXEL_BITS-1:0] hist_reg [MAX_TAPS][fhrf_pkg::NUM_CHANNELS];
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [CNT_W-1:0]      cnt_inc;

    // Job register: which column to issue next
    logic                        job_valid_reg, job_valid_next;
    logic [fhrf_pkg::HALF_W-1:0] job_d_reg,     job_d_next;
    logic [fhrf_pkg::HALF_W-1:0] job_h_reg,     job_h_next;
    logic [CNT_W-1:0]            job_cnt_reg,   job_cnt_next;
    logic                        job_flush_reg, job_flush_next;

    // Stage flags
    logic s1_valid_reg, s1_row_end_reg, s1_last_reg;
    logic s2_valid_reg, s2_row_end_reg, s2_last_reg;

    logic                        pixel_acc;
    logic                        job_final;
    logic                        issue;
    logic                        s1_can;
    logic                        s2_can;
    logic [fhrf_pkg::HALF_W-1:0] half;
    logic [fhrf_pkg::HALF_W-1:0] first_d;
    logic [2:0]                  reach;
    logic [2:0]                  back;
    int                          taps;

    logic [PIXEL_BITS-1:0] tap_op [fhrf_pkg::NUM_CHANNELS][fhrf_pkg::NUM_COEFS];
    fhrf_pkg::sample_t     ch_value [fhrf_pkg::NUM_CHANNELS];
    logic                  ch_clip  [fhrf_pkg::NUM_CHANNELS];
    fhrf_pkg::pipe_ctrl_t  ctrl;

    // Take config writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= fhrf_pkg::TAP_COUNT_RESET;
            for (int i = 0; i < fhrf_pkg::NUM_COEFS; i++)
            begin
                coef_reg[i] <= (i == 0) ? fhrf_pkg::COEF_UNITY : '0;
            end
        end
        else if (cfg.valid)
        begin
            if (cfg.index == fhrf_pkg::REG_TAP_COUNT)
            begin
                tap_count_reg <= cfg.data[fhrf_pkg::TAP_CNT_W-1:0];
            end
            for (int i = 0; i < fhrf_pkg::NUM_COEFS; i++)
            begin
                if (cfg.index == fhrf_pkg::REG_COEF_BASE + fhrf_pkg::CFG_IDX_W'(i))
                begin
                    coef_reg[i] <= cfg.data;
                end
            end
        end
    end

    // Effective tap count: clamp to MAX_TAPS, drop an even count by one, zero means one
    always_comb
    begin
        taps = int'(tap_count_reg);
        if (taps > MAX_TAPS)
        begin
            taps = MAX_TAPS;
        end
        if ((taps & 1) == 0)
        begin
            taps = (taps == 0) ? 1 : taps - 1;
        end
        half = fhrf_pkg::HALF_W'((taps - 1) >> 1);
    end

    // Handshake between stages
    assign s2_can    = !s2_valid_reg || result.ready;
    assign s1_can    = !s1_valid_reg || s2_can;
    assign job_final = !job_flush_reg || (job_d_reg == '0);
    assign issue     = job_valid_reg && s1_can;
    assign pixel.ready = !job_valid_reg || (issue && job_final);
    assign pixel_acc = pixel.valid && pixel.ready;

    // Pixel count of the current row, saturating at MAX_TAPS
    always_comb
    begin
        cnt_inc = (cnt_reg < CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
        if (int'(cnt_inc) - 1 > int'(half))
        begin
            first_d = half;
        end
        else
        begin
            first_d = fhrf_pkg::HALF_W'(cnt_inc - 1'b1);
        end
        cnt_next = cnt_reg;
        if (pixel_acc)
        begin
            cnt_next = pixel.row_last ? '0 : cnt_inc;
        end
    end

    // Load a new job on a beat, else step down through the pending columns
    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_d_next     = job_d_reg;
        job_h_next     = job_h_reg;
        job_cnt_next   = job_cnt_reg;
        job_flush_next = job_flush_reg;
        if (pixel_acc)
        begin
            job_valid_next = pixel.row_last || (int'(cnt_inc) > int'(half));
            job_d_next     = pixel.row_last ? first_d : half;
            job_h_next     = half;
            job_cnt_next   = cnt_inc;
            job_flush_next = pixel.row_last;
        end
        else if (issue)
        begin
            if (job_final)
            begin
                job_valid_next = 1'b0;
            end
            else
            begin
                job_d_next = job_d_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_d_reg     <= job_d_next;
        job_h_reg     <= job_h_next;
        job_cnt_reg   <= job_cnt_next;
        job_flush_reg <= job_flush_next;
    end

    // Shift the new pixel into the history
    always_ff @(posedge clk)
    begin
        if (pixel_acc)
        begin
            for (int k = MAX_TAPS - 1; k > 0; k--)
            begin
                hist_reg[k] <= hist_reg[k - 1];
            end
            hist_reg[0][fhrf_pkg::CH_RED]   <= pixel.red_in;
            hist_reg[0][fhrf_pkg::CH_GREEN] <= pixel.green_in;
            hist_reg[0][fhrf_pkg::CH_BLUE]  <= pixel.blue_in;
        end
    end

    // Pick the pixel under each tap; taps off the row or outside the window read zero
    always_comb
    begin
        reach = {1'b0, job_d_reg} + {1'b0, job_h_reg};
        back  = '0;
        for (int t = 0; t < fhrf_pkg::NUM_COEFS; t++)
        begin
            for (int c = 0; c < fhrf_pkg::NUM_CHANNELS; c++)
            begin
                tap_op[c][t] = '0;
            end
            if (t <= 2 * int'(job_h_reg) && int'(reach) >= t)
            begin
                back = reach - 3'(t);
                for (int k = 0; k < MAX_TAPS; k++)
                begin
                    if (int'(back) == k && k < int'(job_cnt_reg))
                    begin
                        for (int c = 0; c < fhrf_pkg::NUM_CHANNELS; c++)
                        begin
                            tap_op[c][t] = hist_reg[k][c];
                        end
                    end
                end
            end
        end
    end

    assign ctrl.prod_load = issue;
    assign ctrl.sum_load  = s1_valid_reg && s2_can;

    for (genvar c = 0; c < fhrf_pkg::NUM_CHANNELS; c++)
    begin : g_chan
        fhrf_channel #(
            .PIXEL_BITS (PIXEL_BITS)
        ) u_chan (
            .clk     (clk),
            .ctrl    (ctrl),
            .operand (tap_op[c]),
            .coef    (coef_reg),
            .value   (ch_value[c]),
            .clip    (ch_clip[c])
        );
    end

    // Advance the stage flags alongside the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_can)
            begin
                s1_valid_reg <= issue;
            end
            if (s2_can)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_row_end_reg <= job_flush_reg && (job_d_reg == '0);
            s1_last_reg    <= job_final;
        end
        if (ctrl.sum_load)
        begin
            s2_row_end_reg <= s1_row_end_reg;
            s2_last_reg    <= s1_last_reg;
        end
    end

    // Drive the result beat
    assign result.valid       = s2_valid_reg;
    assign result.red_out     = ch_value[fhrf_pkg::CH_RED];
    assign result.green_out   = ch_value[fhrf_pkg::CH_GREEN];
    assign result.blue_out    = ch_value[fhrf_pkg::CH_BLUE];
    assign result.clipped     = ch_clip[fhrf_pkg::CH_RED] || ch_clip[fhrf_pkg::CH_GREEN]
                                || ch_clip[fhrf_pkg::CH_BLUE];
    assign result.row_end     = s2_row_end_reg;
    assign result.last_of_run = s2_last_reg;

    `FHRF_ASSERT_NOW(a_job_col_in_window, job_valid_reg, job_d_reg <= job_h_reg)
    `FHRF_ASSERT_NEXT(a_flush_steps_down, issue && !job_final,
                      job_valid_reg && (job_d_reg == $past(job_d_reg) - 1'b1))
    `FHRF_ASSERT_NOW(a_row_end_closes_run, s2_valid_reg && s2_row_end_reg, s2_last_reg)
    `FHRF_ASSERT_NEXT(a_row_last_clears_cnt, pixel_acc && pixel.row_last, cnt_reg == '0)

endmodule
